@@ rtl/iso2ms_pkg.sv @@
// ----------------------------------------------------------------------------
// iso2ms_pkg: shared types and constants of the timestamp converter
// Field record, multiply-accumulate command, status codes, layout of the
// fixed-format text and the arithmetic constants of the date conversion.
// ----------------------------------------------------------------------------
package iso2ms_pkg;

	localparam int TEXT_LENGTH = 20;
	localparam int POS_W       = 5;
	localparam int ACC_W       = 50;
	localparam int OPA_W       = 24;
	localparam int OPB_W       = 28;

	localparam logic [1:0] STATUS_OK           = 2'd0;
	localparam logic [1:0] STATUS_WRONG_LENGTH = 2'd1;
	localparam logic [1:0] STATUS_BAD_LAYOUT   = 2'd2;

	localparam logic [13:0] EPOCH_YEAR = 14'd1970;
	localparam int EPOCH_DAYS    = 719468;
	localparam int DIV100_MUL    = 5243;
	localparam int DIV100_SHIFT  = 19;
	localparam int DAYS_PER_YEAR = 365;
	localparam int MS_PER_DAY    = 86400000;
	localparam int MS_PER_HOUR   = 3600000;
	localparam int MS_PER_MINUTE = 60000;
	localparam int MS_PER_SECOND = 1000;

	typedef struct packed {
		logic [13:0] year;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} fields_t;

	typedef struct packed {
		logic                    en;
		logic                    load;
		logic signed [OPA_W-1:0] a;
		logic [OPB_W-1:0]        b;
		logic signed [OPA_W-1:0] c;
	} mac_op_t;

	// Separator expected at a place of the text; zero where a digit belongs.
	function automatic logic [7:0] sep_char(logic [POS_W-1:0] pos);
		logic [7:0] s;
		case (pos) inside
			5'd4, 5'd7:   s = 8'h2D;
			5'd10:        s = 8'h54;
			5'd13, 5'd16: s = 8'h3A;
			5'd19:        s = 8'h5A;
			default:      s = 8'h00;
		endcase
		return s;
	endfunction

	// Days from March 1 to the first of the month, month counted from 0 = January.
	function automatic logic [8:0] days_before(logic [3:0] mon);
		logic [8:0] d;
		case (mon)
			4'd0:    d = 9'd306;
			4'd1:    d = 9'd337;
			4'd2:    d = 9'd0;
			4'd3:    d = 9'd31;
			4'd4:    d = 9'd61;
			4'd5:    d = 9'd92;
			4'd6:    d = 9'd122;
			4'd7:    d = 9'd153;
			4'd8:    d = 9'd184;
			4'd9:    d = 9'd214;
			4'd10:   d = 9'd245;
			4'd11:   d = 9'd275;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

@@ rtl/iso8601_utc_to_epoch_ms_unit.sv @@
// ----------------------------------------------------------------------------
// iso8601_utc_to_epoch_ms_unit: timestamp text to epoch milliseconds
// Scans YYYY-MM-DDTHH:MM:SSZ one character per word and, after the last
// character, computes milliseconds since 1970 on one shared multiplier.
//
//   channel  signals                       direction  word
//   input    in_valid, in_ready            in         ch, is_last
//   output   out_valid, out_ready          out        status, time_ms
//
// Characters are taken while the sequencer is idle. After the last one the
// sequencer runs check, divide by 100, day count, four multiply-accumulate
// steps and done on the shared multiplier, or check and done for an error or
// early year. The input is held off from the last character until the result
// is loaded. A waiting result does not block characters of the next text.
// Reset clears the scanner, the sequencer and the output valid.
// ----------------------------------------------------------------------------
module iso8601_utc_to_epoch_ms_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [47:0] time_ms
);

	typedef enum logic [8:0] {
		ST_IDLE     = 9'b000000001,
		ST_CHECK    = 9'b000000010,
		ST_DIV      = 9'b000000100,
		ST_DAYS     = 9'b000001000,
		ST_MS_DAY   = 9'b000010000,
		ST_MS_HOUR  = 9'b000100000,
		ST_MS_MIN   = 9'b001000000,
		ST_MS_SEC   = 9'b010000000,
		ST_DONE     = 9'b100000000
	} state_t;

	state_t      state_q;
	logic [1:0]  status_q;
	logic        zero_q;
	logic [13:0] yadj_q;
	logic [3:0]  mon_q;
	logic        out_valid_q;
	logic [1:0]  out_status_q;
	logic [47:0] out_time_q;

	logic                                take;
	logic                                len_ok;
	logic                                bad_now;
	logic                                clear;
	logic                                load_out;
	iso2ms_pkg::fields_t                 fields;
	iso2ms_pkg::mac_op_t                 mac_op;
	logic signed [iso2ms_pkg::ACC_W-1:0] acc;

	logic [6:0]        m0;
	logic [3:0]        yq;
	logic [6:0]        mrem;
	logic [13:0]       ycal;
	logic [3:0]        mon_d;
	logic [13:0]       yadj_d;
	logic [6:0]        q100;
	logic [23:0]       base_u;
	logic [47:0]       result;

	assign in_ready = state_q == ST_IDLE;
	assign take     = in_valid && in_ready;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign clear    = load_out;

	iso2ms_collect u_collect (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.clear   (clear),
		.ch      (ch),
		.len_ok  (len_ok),
		.bad_now (bad_now),
		.fields  (fields)
	);

	iso2ms_mac u_mac (
		.clk (clk),
		.op  (mac_op),
		.acc (acc)
	);

	// Month carry into the year: month 0 is December of the year before.
	always_comb begin
		m0 = fields.month - 7'd1;
		yq = 4'd0;
		for (int k = 1; k <= 8; k++) begin
			if (m0 >= 7'(12 * k)) begin
				yq = yq + 4'd1;
			end
		end
		mrem = 7'(m0 - 7'(yq) * 7'd12);
		if (fields.month == 7'd0) begin
			ycal  = fields.year - 14'd1;
			mon_d = 4'd11;
		end else begin
			ycal  = fields.year + 14'(yq);
			mon_d = mrem[3:0];
		end
		// Years start in March, so January and February count to the year before.
		yadj_d = ycal - 14'(mon_d < 4'd2);
	end

	always_comb begin
		q100   = acc[iso2ms_pkg::DIV100_SHIFT+6:iso2ms_pkg::DIV100_SHIFT];
		base_u = 24'(yadj_q >> 2) - 24'(q100) + 24'(q100 >> 2)
			+ 24'(iso2ms_pkg::days_before(mon_q)) + 24'(fields.day) - 24'd1
			- 24'(iso2ms_pkg::EPOCH_DAYS);
	end

	always_comb begin
		mac_op = '0;
		case (state_q)
			ST_DIV: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = $signed(24'(yadj_q));
				mac_op.b    = 28'(iso2ms_pkg::DIV100_MUL);
			end
			ST_DAYS: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = $signed(24'(yadj_q));
				mac_op.b    = 28'(iso2ms_pkg::DAYS_PER_YEAR);
				mac_op.c    = $signed(base_u);
			end
			ST_MS_DAY: begin
				mac_op.en   = 1'b1;
				mac_op.load = 1'b1;
				mac_op.a    = acc[23:0];
				mac_op.b    = 28'(iso2ms_pkg::MS_PER_DAY);
			end
			ST_MS_HOUR: begin
				mac_op.en = 1'b1;
				mac_op.a  = $signed(24'(fields.hour));
				mac_op.b  = 28'(iso2ms_pkg::MS_PER_HOUR);
			end
			ST_MS_MIN: begin
				mac_op.en = 1'b1;
				mac_op.a  = $signed(24'(fields.minute));
				mac_op.b  = 28'(iso2ms_pkg::MS_PER_MINUTE);
			end
			ST_MS_SEC: begin
				mac_op.en = 1'b1;
				mac_op.a  = $signed(24'(fields.second));
				mac_op.b  = 28'(iso2ms_pkg::MS_PER_SECOND);
			end
			default: mac_op = '0;
		endcase
	end

	// A moment at or before the epoch reads as zero.
	always_comb begin
		if (zero_q || acc[iso2ms_pkg::ACC_W-1] || acc == '0) begin
			result = '0;
		end else if (acc[iso2ms_pkg::ACC_W-2:48] != '0) begin
			result = '1;
		end else begin
			result = acc[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			status_q <= iso2ms_pkg::STATUS_OK;
			zero_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take && is_last) begin
						if (!len_ok) begin
							status_q <= iso2ms_pkg::STATUS_WRONG_LENGTH;
						end else if (bad_now) begin
							status_q <= iso2ms_pkg::STATUS_BAD_LAYOUT;
						end else begin
							status_q <= iso2ms_pkg::STATUS_OK;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (status_q != iso2ms_pkg::STATUS_OK
						|| fields.year < iso2ms_pkg::EPOCH_YEAR) begin
						zero_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						zero_q  <= 1'b0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV:     state_q <= ST_DAYS;
				ST_DAYS:    state_q <= ST_MS_DAY;
				ST_MS_DAY:  state_q <= ST_MS_HOUR;
				ST_MS_HOUR: state_q <= ST_MS_MIN;
				ST_MS_MIN:  state_q <= ST_MS_SEC;
				ST_MS_SEC:  state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK) begin
			yadj_q <= yadj_d;
			mon_q  <= mon_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= status_q;
			out_time_q   <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign time_ms   = out_time_q;

	// An error word never carries a time.
	a_err_no_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == iso2ms_pkg::STATUS_OK || time_ms == 48'd0))
		else $error("error word with nonzero time");

	// The last character holds off the input until the result is out.
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && is_last |=> !in_ready)
		else $error("input taken right after last character");

	// The arithmetic only runs for a well-formed text from 1970 on.
	a_calc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> (status_q == iso2ms_pkg::STATUS_OK
			&& fields.year >= iso2ms_pkg::EPOCH_YEAR))
		else $error("conversion started on a rejected text");

	// The day count can fall at most a month and a day before the epoch.
	a_days_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MS_DAY |-> acc >= -50'sd32)
		else $error("day count below range");

endmodule

@@ rtl/iso2ms_collect.sv @@
// ----------------------------------------------------------------------------
// iso2ms_collect: character scanner
// Counts characters, checks each against the fixed layout and builds the six
// decimal fields from the digits at their places.
// ----------------------------------------------------------------------------
module iso2ms_collect (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  take,
	input  logic                  clear,
	input  logic [7:0]            ch,
	output logic                  len_ok,
	output logic                  bad_now,
	output iso2ms_pkg::fields_t   fields
);

	logic [iso2ms_pkg::POS_W-1:0] pos_q;
	logic                         err_q;
	iso2ms_pkg::fields_t          fld_q;

	logic [7:0] sep;
	logic       in_text;
	logic       digit_ok;
	logic       char_bad;
	logic [3:0] d;

	always_comb begin
		sep      = iso2ms_pkg::sep_char(pos_q);
		in_text  = pos_q < iso2ms_pkg::POS_W'(iso2ms_pkg::TEXT_LENGTH);
		digit_ok = (ch >= 8'h30) && (ch <= 8'h39);
		char_bad = in_text && ((sep != 8'h00) ? (ch != sep) : !digit_ok);
		d        = 4'(ch - 8'h30);
	end

	assign len_ok  = pos_q == iso2ms_pkg::POS_W'(iso2ms_pkg::TEXT_LENGTH - 1);
	assign bad_now = err_q | char_bad;
	assign fields  = fld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			err_q <= 1'b0;
			fld_q <= '0;
		end else if (clear) begin
			pos_q <= '0;
			err_q <= 1'b0;
			fld_q <= '0;
		end else if (take) begin
			// The count saturates so that an overlong text never looks right.
			if (pos_q != '1) begin
				pos_q <= pos_q + 1'b1;
			end
			if (char_bad) begin
				err_q <= 1'b1;
			end
			if (in_text && sep == 8'h00 && digit_ok) begin
				case (pos_q) inside
					[5'd0:5'd3]:   fld_q.year   <= 14'(fld_q.year * 14'd10 + 14'(d));
					[5'd5:5'd6]:   fld_q.month  <= 7'(fld_q.month * 7'd10 + 7'(d));
					[5'd8:5'd9]:   fld_q.day    <= 7'(fld_q.day * 7'd10 + 7'(d));
					[5'd11:5'd12]: fld_q.hour   <= 7'(fld_q.hour * 7'd10 + 7'(d));
					[5'd14:5'd15]: fld_q.minute <= 7'(fld_q.minute * 7'd10 + 7'(d));
					default:       fld_q.second <= 7'(fld_q.second * 7'd10 + 7'(d));
				endcase
			end
		end
	end

endmodule

@@ rtl/iso2ms_mac.sv @@
// ----------------------------------------------------------------------------
// iso2ms_mac: shared multiply-accumulate unit
// One signed multiply per cycle while enabled, with an addend, either loading or
// adding to the accumulator that holds the running result.
// ----------------------------------------------------------------------------
module iso2ms_mac (
	input  logic                                clk,
	input  iso2ms_pkg::mac_op_t                 op,
	output logic signed [iso2ms_pkg::ACC_W-1:0] acc
);

	localparam int PROD_W = iso2ms_pkg::OPA_W + iso2ms_pkg::OPB_W + 1;

	logic signed [iso2ms_pkg::ACC_W-1:0] acc_q;
	logic signed [PROD_W-1:0]            prod;
	logic signed [iso2ms_pkg::ACC_W-1:0] base;
	logic signed [iso2ms_pkg::ACC_W-1:0] addend;

	always_comb begin
		prod   = op.a * $signed({1'b0, op.b});
		base   = op.load ? '0 : acc_q;
		addend = {{(iso2ms_pkg::ACC_W - iso2ms_pkg::OPA_W){op.c[iso2ms_pkg::OPA_W-1]}}, op.c};
	end

	always_ff @(posedge clk) begin
		if (op.en) begin
			acc_q <= base + prod[iso2ms_pkg::ACC_W-1:0] + addend;
		end
	end

	assign acc = acc_q;

endmodule

@@ bench/iso8601_utc_to_epoch_ms_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iso8601_utc_to_epoch_ms_unit_tb: self-checking bench of the timestamp converter
// Streams timestamp texts one character per word. A scoreboard follows the
// scanner and the calendar arithmetic and compares every status and time_ms.
// Corner texts come first. Then come random well-formed, corrupted, short,
// long and noise texts, with random stalls on both channels and one long
// hold-off at the output.
// ----------------------------------------------------------------------------
module iso8601_utc_to_epoch_ms_unit_tb;

	localparam int     CYCLE_LIMIT  = 400000;
	localparam int     RANDOM_WORDS = 720;
	localparam int     LONG_HOLD    = 300;
	localparam longint MS_MAX       = 64'h0000_FFFF_FFFF_FFFF;

	class stamp_scoreboard;
		typedef struct {
			logic [1:0]  status;
			logic [47:0] ms;
		} stamp_result_t;

		logic [4:0]          pos;
		logic                broken;
		iso2ms_pkg::fields_t f;
		stamp_result_t       pending[$];
		int                  errors;
		int                  checked;
		int                  n_ok;
		int                  n_length;
		int                  n_layout;

		function new();
			clear_text();
		endfunction

		function void clear_text();
			pos = '0;
			broken = 1'b0;
			f = '0;
		endfunction

		// Follows one accepted character; on the last one queues the result.
		function void note_word(logic [7:0] c, logic last);
			logic [7:0]    sep;
			logic [3:0]    dig;
			int            len;
			longint        yr, mo, dy, era, yoe, doy, doe, secs;
			stamp_result_t r;

			if (pos < iso2ms_pkg::TEXT_LENGTH) begin
				case (pos)
					5'd4, 5'd7:   sep = "-";
					5'd10:        sep = "T";
					5'd13, 5'd16: sep = ":";
					5'd19:        sep = "Z";
					default:      sep = 8'h00;
				endcase
				if (sep != 8'h00) begin
					if (c != sep)
						broken = 1'b1;
				end else if (c < "0" || c > "9") begin
					broken = 1'b1;
				end else begin
					dig = 4'(c - "0");
					if (pos < 4)
						f.year = 14'(f.year * 10 + dig);
					else if (pos < 7)
						f.month = 7'(f.month * 10 + dig);
					else if (pos < 10)
						f.day = 7'(f.day * 10 + dig);
					else if (pos < 13)
						f.hour = 7'(f.hour * 10 + dig);
					else if (pos < 16)
						f.minute = 7'(f.minute * 10 + dig);
					else
						f.second = 7'(f.second * 10 + dig);
				end
			end
			len = pos + 1;
			if (pos != 5'd31)
				pos++;
			if (!last)
				return;

			r.ms = 48'd0;
			if (len != iso2ms_pkg::TEXT_LENGTH) begin
				r.status = iso2ms_pkg::STATUS_WRONG_LENGTH;
				n_length++;
			end else if (broken) begin
				r.status = iso2ms_pkg::STATUS_BAD_LAYOUT;
				n_layout++;
			end else begin
				r.status = iso2ms_pkg::STATUS_OK;
				n_ok++;
				if (f.year >= iso2ms_pkg::EPOCH_YEAR) begin
					yr = f.year;
					mo = f.month;
					dy = f.day;
					// Month 0 is December of the year before; months past 12 carry.
					if (mo == 0) begin
						yr--;
						mo = 12;
					end else begin
						yr += (mo - 1) / 12;
						mo = (mo - 1) % 12 + 1;
					end
					// Civil date to day count with the year starting on March 1.
					if (mo <= 2)
						yr--;
					era = yr / 400;
					yoe = yr - era * 400;
					doy = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + dy - 1;
					doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
					secs = (era * 146097 + doe - iso2ms_pkg::EPOCH_DAYS) * 86400
					     + longint'(f.hour) * 3600 + longint'(f.minute) * 60
					     + longint'(f.second);
					if (secs * 1000 > MS_MAX)
						r.ms = '1;
					else if (secs > 0)
						r.ms = 48'(secs * 1000);
				end
			end
			pending.push_back(r);
			clear_text();
		endfunction

		function void check_result(logic [1:0] st, logic [47:0] ms);
			stamp_result_t e;
			if (pending.size() == 0) begin
				$error("result with none expected: status %0d time_ms %0d", st, ms);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				errors++;
			end
			if (ms !== e.ms) begin
				$error("time_ms: expected %0d, got %0d", e.ms, ms);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  ch = 8'h00;
	logic        is_last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [47:0] time_ms;

	stamp_scoreboard sb;
	logic [7:0]      text_q[$];
	bit              tx_idle = 1'b0;
	bit              rx_idle = 1'b0;
	bit              long_hold_req = 1'b0;
	int              words_sent = 0;
	int              texts_sent = 0;

	iso8601_utc_to_epoch_ms_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.ch        (ch),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.time_ms   (time_ms)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void load_stamp(int yr, int mo, int dy, int hr, int mi, int se);
		string s;
		s = $sformatf("%04d-%02d-%02dT%02d:%02d:%02dZ", yr, mo, dy, hr, mi, se);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	// Mostly a sensible value, now and then any two-digit value.
	function automatic int pick(int lo, int hi);
		return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 99) : $urandom_range(lo, hi);
	endfunction

	function automatic void random_stamp();
		int yr;
		case ($urandom_range(0, 9))
			0:       yr = $urandom_range(0, 9999);
			1:       yr = $urandom_range(1960, 1975);
			default: yr = $urandom_range(1970, 2100);
		endcase
		load_stamp(yr, pick(1, 12), pick(1, 28), pick(0, 23), pick(0, 59), pick(0, 59));
	endfunction

	task automatic send_word(input logic [7:0] c, input logic last);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		is_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(c, last);
		words_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_word(text_q[i], i == text_q.size() - 1);
		texts_sent++;
	endtask

	// Output side: checks every accepted word and stalls in bursts.
	initial begin : receiver
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result(status, time_ms);
			if (hold > 0) begin
				hold--;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold = LONG_HOLD;
			end else if (rx_idle && $urandom_range(0, 7) == 0) begin
				hold = $urandom_range(1, 19);
			end
			out_ready <= (hold == 0);
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("iso8601_utc_to_epoch_ms_unit_tb: errors");
		$finish;
	end

	initial begin : stimulus
		int  kind;
		int  start;
		bit  hold_done;
		sb = new();
		hold_done = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The epoch itself maps to zero, one second later to 1000.
		load_stamp(1970, 1, 1, 0, 0, 0);
		send_text();
		load_stamp(1970, 1, 1, 0, 0, 1);
		send_text();
		// Early years give zero with status ok, then nines in every field.
		load_stamp(0, 0, 0, 0, 0, 0);
		send_text();
		load_stamp(1969, 12, 31, 23, 59, 59);
		send_text();
		load_stamp(9999, 99, 99, 99, 99, 99);
		send_text();
		// Month 0 and day 0 reach back before the epoch; month 13 carries into 2025.
		load_stamp(1970, 0, 15, 0, 0, 0);
		send_text();
		load_stamp(1970, 1, 0, 0, 0, 0);
		send_text();
		load_stamp(2024, 13, 0, 12, 34, 56);
		send_text();
		// Broken separator, then a non-digit in the year.
		load_stamp(2024, 2, 29, 12, 0, 0);
		text_q[10] = " ";
		send_text();
		load_stamp(2001, 9, 9, 1, 46, 40);
		text_q[2] = "a";
		send_text();
		// Lengths of 1, 19, 21 and 35 characters; the last one saturates the count.
		text_q.delete();
		text_q.push_back("Z");
		send_text();
		load_stamp(2000, 1, 1, 0, 0, 0);
		void'(text_q.pop_back());
		send_text();
		load_stamp(2000, 1, 1, 0, 0, 0);
		text_q.push_back("Z");
		send_text();
		load_stamp(2038, 1, 19, 3, 14, 7);
		repeat (15) text_q.push_back(8'($urandom_range(0, 255)));
		send_text();

		tx_idle = 1'b1;
		rx_idle = 1'b1;
		start = words_sent;
		while (words_sent - start < RANDOM_WORDS) begin
			if (words_sent - start >= RANDOM_WORDS * 8 / 10) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			if (!hold_done && words_sent - start >= 300) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			kind = $urandom_range(0, 99);
			random_stamp();
			if (kind < 60) begin
				// well-formed text as is
			end else if (kind < 78) begin
				text_q[$urandom_range(0, 19)] = 8'($urandom_range(0, 255));
			end else if (kind < 88) begin
				repeat ($urandom_range(1, 19)) void'(text_q.pop_back());
			end else if (kind < 94) begin
				repeat ($urandom_range(1, 20)) text_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				text_q.delete();
				repeat ($urandom_range(1, 24)) text_q.push_back(8'($urandom_range(0, 255)));
			end
			send_text();
		end
		in_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		$display("Sent %0d characters in %0d texts and compared %0d results.",
		         words_sent, texts_sent, sb.checked);
		$display("Expected %0d ok, %0d wrong length, %0d bad layout; one %0d-cycle output hold.",
		         sb.n_ok, sb.n_length, sb.n_layout, LONG_HOLD);
		if (sb.errors == 0)
			$display("iso8601_utc_to_epoch_ms_unit_tb: clean");
		else
			$display("iso8601_utc_to_epoch_ms_unit_tb: errors");
		$finish;
	end

endmodule
